/* rtl/cffs_pkg.sv */
// ----------------------------------------------------------------------------
// Credit flow frame scheduler package
// Shared constants, function codes and payload types for the scheduler.
// ----------------------------------------------------------------------------
package cffs_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [13:0] LEN_MAX  = 14'h3fff;
  localparam logic [13:0] CTRL_LEN = 14'd2;

  localparam logic [2:0] FUNC_QUEUE_METER   = 3'd0;
  localparam logic [2:0] FUNC_QUEUE_DISPLAY = 3'd1;
  localparam logic [2:0] FUNC_FLOW_UPDATE   = 3'd2;
  localparam logic [2:0] FUNC_FLUSH         = 3'd3;
  localparam logic [2:0] FUNC_RESET_FLOW    = 3'd4;

  localparam logic KIND_CTRL = 1'b0;
  localparam logic KIND_DISP = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  target;
    logic [15:0] pattern;
    logic [31:0] payload_ref;
    logic [15:0] payload_len;
    logic [7:0]  dev_slave_count;
    logic [7:0]  dev_display_credits;
    logic [7:0]  dev_control_credits;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        frame_valid;
    logic        frame_kind;
    logic [7:0]  frame_target;
    logic [15:0] frame_seq;
    logic [31:0] frame_data;
    logic [13:0] frame_len;
    logic        last;
    logic [7:0]  control_credits;
    logic [7:0]  display_credits;
    logic        flow_known;
    logic [7:0]  slave_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic pick;
    logic load_frame;
    logic load_empty;
  } cffs_cmd_t;

  typedef struct packed {
    logic has_frames;
    logic more;
    logic can_load;
  } cffs_sts_t;

endpackage

/* rtl/cffs_datapath.sv */
// ----------------------------------------------------------------------------
// Credit flow frame scheduler datapath
// Slot stores, occupancy, credit and sequence registers, and the result
// register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module cffs_datapath import cffs_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned ICON_BYTES = 12800
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cffs_cmd_t cmd_i,
  output cffs_sts_t sts_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  output out_item_t out_o,
  input  logic      out_stall_i
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam logic [8:0]  SlotsLim = 9'(SLOTS);
  localparam logic [15:0] IconLim  = 16'(ICON_BYTES);
  localparam logic [8:0]  MaxLim   = 9'(MAX_RESULTS);

  function automatic logic [SW-1:0] lowest_set(input logic [SLOTS-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [PW-1:0] popcount(input logic [SLOTS-1:0] v);
    logic [PW-1:0] c;
    c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      c = c + PW'(v[i]);
    end
    return c;
  endfunction

  in_item_t             req_q;
  logic [SLOTS-1:0]     ctrl_occ_q;
  logic [SLOTS-1:0]     disp_occ_q;
  logic [15:0]          ctrl_seq_q;
  logic [15:0]          disp_seq_q;
  logic [7:0]           cc_q;
  logic [7:0]           dc_q;
  logic                 flow_q;
  logic [7:0]           slaves_q;
  logic [CNT_W-1:0]     rem_c_q;
  logic [CNT_W-1:0]     rem_d_q;
  logic                 acc_q;
  logic                 kind_q;
  logic [SW-1:0]        slot_q;
  logic                 last_q;
  logic                 out_valid_q;
  out_item_t            out_q;
  out_item_t            out_d;

  logic [31:0]          ctrl_mem [SLOTS];
  logic [61:0]          disp_mem [SLOTS];
  logic [31:0]          ctrl_rd_q;
  logic [61:0]          disp_rd_q;

  logic                 tgt_ok;
  logic [SW-1:0]        tgt_idx;
  logic                 meter_ok;
  logic                 disp_ok;
  logic [15:0]          len_icon;
  logic [13:0]          len_clamp;
  logic [8:0]           pop_c;
  logic [8:0]           pop_d;
  logic [8:0]           tc;
  logic [8:0]           td;
  logic [8:0]           lim_d;
  logic [CNT_W-1:0]     nc;
  logic [CNT_W-1:0]     nd;
  logic                 pick_ctrl;
  logic [SW-1:0]        pick_slot;
  logic [CNT_W:0]       rem_sum;
  logic                 do_meter;
  logic                 do_disp;

  always_comb begin
    tgt_ok    = {1'b0, req_q.target} < SlotsLim;
    tgt_idx   = req_q.target[SW-1:0];
    meter_ok  = tgt_ok;
    disp_ok   = tgt_ok && (req_q.payload_ref != '0) && (req_q.payload_len != '0);
    do_meter  = cmd_i.exec && (req_q.func == FUNC_QUEUE_METER) && meter_ok;
    do_disp   = cmd_i.exec && (req_q.func == FUNC_QUEUE_DISPLAY) && disp_ok;
    len_icon  = (req_q.payload_len > IconLim) ? IconLim : req_q.payload_len;
    len_clamp = (len_icon > 16'(LEN_MAX)) ? LEN_MAX : len_icon[13:0];

    pop_c = 9'(popcount(ctrl_occ_q));
    pop_d = 9'(popcount(disp_occ_q));
    tc    = ({1'b0, cc_q} < pop_c) ? {1'b0, cc_q} : pop_c;
    tc    = (tc < MaxLim) ? tc : MaxLim;
    nc    = flow_q ? tc[CNT_W-1:0] : '0;
    lim_d = MaxLim - 9'(nc);
    td    = ({1'b0, dc_q} < pop_d) ? {1'b0, dc_q} : pop_d;
    td    = (td < lim_d) ? td : lim_d;
    nd    = flow_q ? td[CNT_W-1:0] : '0;

    pick_ctrl = (rem_c_q != '0);
    pick_slot = lowest_set(pick_ctrl ? ctrl_occ_q : disp_occ_q);
    rem_sum   = (CNT_W+1)'(rem_c_q) + (CNT_W+1)'(rem_d_q);

    sts_o.has_frames = (req_q.func == FUNC_FLUSH) && ((nc != '0) || (nd != '0));
    sts_o.more       = (rem_c_q != '0) || (rem_d_q != '0);
    sts_o.can_load   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.load_empty) begin
      out_d                 = '0;
      out_d.accepted        = acc_q;
      out_d.last            = 1'b1;
      out_d.control_credits = cc_q;
      out_d.display_credits = dc_q;
      out_d.flow_known      = flow_q;
      out_d.slave_count     = slaves_q;
    end else if (cmd_i.load_frame) begin
      out_d.accepted        = acc_q;
      out_d.frame_valid     = 1'b1;
      out_d.frame_kind      = kind_q;
      out_d.frame_target    = 8'(slot_q);
      out_d.frame_seq       = (kind_q == KIND_DISP) ? disp_rd_q[15:0] : ctrl_rd_q[15:0];
      out_d.frame_data      = (kind_q == KIND_DISP) ? disp_rd_q[61:30]
                                                    : {16'b0, ctrl_rd_q[31:16]};
      out_d.frame_len       = (kind_q == KIND_DISP) ? disp_rd_q[29:16] : CTRL_LEN;
      out_d.last            = last_q;
      out_d.control_credits = cc_q;
      out_d.display_credits = dc_q;
      out_d.flow_known      = flow_q;
      out_d.slave_count     = slaves_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_occ_q  <= '0;
      disp_occ_q  <= '0;
      ctrl_seq_q  <= 16'd1;
      disp_seq_q  <= 16'd1;
      cc_q        <= '0;
      dc_q        <= '0;
      flow_q      <= 1'b0;
      slaves_q    <= '0;
      rem_c_q     <= '0;
      rem_d_q     <= '0;
      acc_q       <= 1'b0;
      kind_q      <= KIND_CTRL;
      slot_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        unique case (req_q.func)
          FUNC_QUEUE_METER: begin
            acc_q <= meter_ok;
            if (meter_ok) begin
              ctrl_occ_q[tgt_idx] <= 1'b1;
              ctrl_seq_q          <= ctrl_seq_q + 16'd1;
            end
          end
          FUNC_QUEUE_DISPLAY: begin
            acc_q <= disp_ok;
            if (disp_ok) begin
              disp_occ_q[tgt_idx] <= 1'b1;
              disp_seq_q          <= disp_seq_q + 16'd1;
            end
          end
          FUNC_FLOW_UPDATE: begin
            acc_q    <= 1'b1;
            slaves_q <= req_q.dev_slave_count;
            dc_q     <= req_q.dev_display_credits;
            cc_q     <= req_q.dev_control_credits;
            flow_q   <= 1'b1;
          end
          FUNC_FLUSH: begin
            acc_q   <= 1'b1;
            cc_q    <= cc_q - 8'(nc);
            dc_q    <= dc_q - 8'(nd);
            rem_c_q <= nc;
            rem_d_q <= nd;
          end
          FUNC_RESET_FLOW: begin
            acc_q    <= 1'b1;
            cc_q     <= '0;
            dc_q     <= '0;
            slaves_q <= '0;
            flow_q   <= 1'b0;
          end
          default: begin
            acc_q <= 1'b0;
          end
        endcase
      end
      if (cmd_i.pick) begin
        slot_q <= pick_slot;
        last_q <= (rem_sum == (CNT_W+1)'(1));
        if (pick_ctrl) begin
          kind_q                <= KIND_CTRL;
          ctrl_occ_q[pick_slot] <= 1'b0;
          rem_c_q               <= rem_c_q - CNT_W'(1);
        end else begin
          kind_q                <= KIND_DISP;
          disp_occ_q[pick_slot] <= 1'b0;
          rem_d_q               <= rem_d_q - CNT_W'(1);
        end
      end
      if (cmd_i.load_frame || cmd_i.load_empty) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (do_meter) begin
      ctrl_mem[tgt_idx] <= {req_q.pattern, ctrl_seq_q};
    end
    if (cmd_i.pick) begin
      ctrl_rd_q <= ctrl_mem[pick_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_disp) begin
      disp_mem[tgt_idx] <= {req_q.payload_ref, len_clamp, disp_seq_q};
    end
    if (cmd_i.pick) begin
      disp_rd_q <= disp_mem[pick_slot];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/cffs_ctrl.sv */
// ----------------------------------------------------------------------------
// Credit flow frame scheduler controller
// Sequences capture, execution, frame selection and result loading.
// ----------------------------------------------------------------------------
module cffs_ctrl import cffs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cffs_sts_t sts_i,
  output cffs_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_PICK,
    ST_LOAD
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   stall_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.has_frames ? ST_PICK : ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.can_load) begin
          cmd_o.load_empty = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.can_load) begin
          cmd_o.load_frame = 1'b1;
          state_d          = sts_i.more ? ST_PICK : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

/* rtl/credit_flow_frame_scheduler.sv */
// ----------------------------------------------------------------------------
// Credit flow frame scheduler
// Per-target mailbox slots for control and display frames, sent under
// device-granted credits on a flush request.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (in_valid_i, in_stall_o, in_i) and
// results leave on the output channel (out_valid_o, out_stall_i, out_o).
// A transfer happens at a clock edge where valid is high and stall is low.
// The block works on one request at a time and raises in_stall_o from the
// transfer until its last result has been loaded into the output register.
// A request that sends no frame gives one result. A flush that sends frames
// first executes the request and settles the final credit counts; then for
// each frame the sequencer picks the lowest pending slot, control slots
// before display slots, reads its store, and then loads the result register.
// Every result carries the credit state left after the whole request, and
// last marks its final result.
// When the receiver stalls, the result register holds its contents and the
// sequencer waits; the next request is still taken while a result waits.
// Reset empties all slots, clears credits and flow state, and sets both
// sequence counters to one. No clearing pass is needed.
// ----------------------------------------------------------------------------
module credit_flow_frame_scheduler import cffs_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned ICON_BYTES = 12800
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  cffs_cmd_t cmd;
  cffs_sts_t sts;

  cffs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cffs_datapath #(
    .SLOTS      (SLOTS),
    .ICON_BYTES (ICON_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* rtl/cffs_checker.sv */
// ----------------------------------------------------------------------------
// Credit flow frame scheduler checker
// Port-level checks on the scheduler, attached by a bind statement.
// ----------------------------------------------------------------------------
module cffs_checker import cffs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input not stalled while a request is in work.");

  a_frame_needs_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_valid |-> out_o.flow_known && out_o.accepted)
    else $error("Frame sent without known flow.");

  a_ctrl_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_valid && (out_o.frame_kind == KIND_CTRL)
      |-> out_o.frame_len == CTRL_LEN)
    else $error("Control frame with wrong length.");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.frame_valid |-> out_o.last)
    else $error("Result without frame is not marked last.");

endmodule

bind credit_flow_frame_scheduler cffs_checker u_cffs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

/* tb/sv/cffs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit flow frame scheduler checker
// Watches the request and result channels of the scheduler, keeps its own
// copy of the mailbox slots, credits and sequence counters, works out the
// frames that every request transfer must produce and compares each result
// transfer field by field with the oldest frame still due.
// ----------------------------------------------------------------------------
module tb_cffs_checker import cffs_pkg::*; #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned ICON_BYTES = 12800
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_stall_i,
  input  in_item_t  req_i,
  input  logic      rsp_valid_i,
  input  logic      rsp_stall_i,
  input  out_item_t rsp_i,
  output int        errors_o,
  output int        pending_o
);

  logic        ctrl_busy [SLOTS];
  logic [15:0] ctrl_pat  [SLOTS];
  logic [15:0] ctrl_seq  [SLOTS];
  logic        disp_busy [SLOTS];
  logic [31:0] disp_ref  [SLOTS];
  logic [13:0] disp_len  [SLOTS];
  logic [15:0] disp_seq  [SLOTS];
  logic [15:0] ctrl_seq_next;
  logic [15:0] disp_seq_next;
  logic [7:0]  ctrl_credits;
  logic [7:0]  disp_credits;
  logic        flow_seen;
  logic [7:0]  slaves_seen;

  out_item_t frames_due_q [$];
  out_item_t want;

  initial errors_o = 0;

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      errors_o++;
    end
  endfunction

  function automatic void predict_frames(input in_item_t req);
    out_item_t   sent [$];
    out_item_t   frame;
    logic        acc;
    int unsigned len_v;
    int          s;
    acc = 1'b1;
    case (req.func)
      FUNC_QUEUE_METER: begin
        if (req.target >= SLOTS) begin
          acc = 1'b0;
        end else begin
          ctrl_busy[req.target] = 1'b1;
          ctrl_pat[req.target]  = req.pattern;
          ctrl_seq[req.target]  = ctrl_seq_next;
          ctrl_seq_next++;
        end
      end
      FUNC_QUEUE_DISPLAY: begin
        if (req.target >= SLOTS || req.payload_ref == '0 || req.payload_len == '0) begin
          acc = 1'b0;
        end else begin
          len_v = req.payload_len;
          if (len_v > ICON_BYTES) len_v = ICON_BYTES;
          if (len_v > LEN_MAX) len_v = LEN_MAX;
          disp_busy[req.target] = 1'b1;
          disp_ref[req.target]  = req.payload_ref;
          disp_len[req.target]  = 14'(len_v);
          disp_seq[req.target]  = disp_seq_next;
          disp_seq_next++;
        end
      end
      FUNC_FLOW_UPDATE: begin
        slaves_seen  = req.dev_slave_count;
        disp_credits = req.dev_display_credits;
        ctrl_credits = req.dev_control_credits;
        flow_seen    = 1'b1;
      end
      FUNC_FLUSH: begin
        if (flow_seen) begin
          for (s = 0; s < SLOTS; s++) begin
            if (ctrl_credits == '0 || sent.size() >= MAX_RESULTS) break;
            if (ctrl_busy[s]) begin
              frame              = '0;
              frame.frame_valid  = 1'b1;
              frame.frame_kind   = KIND_CTRL;
              frame.frame_target = 8'(s);
              frame.frame_seq    = ctrl_seq[s];
              frame.frame_data   = {16'h0, ctrl_pat[s]};
              frame.frame_len    = CTRL_LEN;
              sent.push_back(frame);
              ctrl_busy[s] = 1'b0;
              ctrl_credits--;
            end
          end
          for (s = 0; s < SLOTS; s++) begin
            if (disp_credits == '0 || sent.size() >= MAX_RESULTS) break;
            if (disp_busy[s]) begin
              frame              = '0;
              frame.frame_valid  = 1'b1;
              frame.frame_kind   = KIND_DISP;
              frame.frame_target = 8'(s);
              frame.frame_seq    = disp_seq[s];
              frame.frame_data   = disp_ref[s];
              frame.frame_len    = disp_len[s];
              sent.push_back(frame);
              disp_busy[s] = 1'b0;
              disp_credits--;
            end
          end
        end
      end
      FUNC_RESET_FLOW: begin
        ctrl_credits = '0;
        disp_credits = '0;
        slaves_seen  = '0;
        flow_seen    = 1'b0;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
    if (sent.size() == 0) begin
      frame = '0;
      sent.push_back(frame);
    end
    foreach (sent[k]) begin
      sent[k].accepted        = acc;
      sent[k].last            = (k == sent.size() - 1);
      sent[k].control_credits = ctrl_credits;
      sent[k].display_credits = disp_credits;
      sent[k].flow_known      = flow_seen;
      sent[k].slave_count     = slaves_seen;
      frames_due_q.push_back(sent[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ctrl_busy[i]) begin
        ctrl_busy[i] = 1'b0;
        disp_busy[i] = 1'b0;
      end
      ctrl_seq_next = 16'd1;
      disp_seq_next = 16'd1;
      ctrl_credits  = '0;
      disp_credits  = '0;
      flow_seen     = 1'b0;
      slaves_seen   = '0;
      frames_due_q.delete();
      pending_o <= 0;
    end else begin
      if (req_valid_i && !req_stall_i) predict_frames(req_i);
      if (rsp_valid_i && !rsp_stall_i) begin
        if (frames_due_q.size() == 0) begin
          $error("Result transfer with no result due");
          errors_o++;
        end else begin
          want = frames_due_q.pop_front();
          check_field("accepted", want.accepted, rsp_i.accepted);
          check_field("frame_valid", want.frame_valid, rsp_i.frame_valid);
          check_field("frame_kind", want.frame_kind, rsp_i.frame_kind);
          check_field("frame_target", want.frame_target, rsp_i.frame_target);
          check_field("frame_seq", want.frame_seq, rsp_i.frame_seq);
          check_field("frame_data", want.frame_data, rsp_i.frame_data);
          check_field("frame_len", want.frame_len, rsp_i.frame_len);
          check_field("last", want.last, rsp_i.last);
          check_field("control_credits", want.control_credits, rsp_i.control_credits);
          check_field("display_credits", want.display_credits, rsp_i.display_credits);
          check_field("flow_known", want.flow_known, rsp_i.flow_known);
          check_field("slave_count", want.slave_count, rsp_i.slave_count);
        end
      end
      pending_o <= frames_due_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit flow frame scheduler testbench
// Drives directed and random requests into the scheduler under changing
// sender and receiver idle rates, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import cffs_pkg::*;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned ICON_BYTES = 12800;

  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        errors;
  int        pending;
  int        in_idle_pct  = 0;
  int        out_idle_pct = 0;

  credit_flow_frame_scheduler #(
    .SLOTS      (SLOTS),
    .ICON_BYTES (ICON_BYTES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  tb_cffs_checker #(
    .SLOTS      (SLOTS),
    .ICON_BYTES (ICON_BYTES)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .req_valid_i (in_valid),
    .req_stall_i (in_stall),
    .req_i       (in_data),
    .rsp_valid_i (out_valid),
    .rsp_stall_i (out_stall),
    .rsp_i       (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic in_item_t make_item(input logic [2:0] func, input logic [7:0] target,
                                         input logic [15:0] pattern,
                                         input logic [31:0] pref, input logic [15:0] plen,
                                         input logic [7:0] slaves, input logic [7:0] dcred,
                                         input logic [7:0] ccred);
    in_item_t req;
    req.func                = func;
    req.target              = target;
    req.pattern             = pattern;
    req.payload_ref         = pref;
    req.payload_len         = plen;
    req.dev_slave_count     = slaves;
    req.dev_display_credits = dcred;
    req.dev_control_credits = ccred;
    return req;
  endfunction

  task automatic send_item(input in_item_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_random(input int count);
    in_item_t req;
    int       pick;
    repeat (count) begin
      req.func                = FUNC_FLUSH;
      req.target              = 8'($urandom);
      req.pattern             = 16'($urandom);
      req.payload_ref         = $urandom;
      req.payload_len         = 16'($urandom);
      req.dev_slave_count     = 8'($urandom);
      req.dev_display_credits = 8'($urandom);
      req.dev_control_credits = 8'($urandom);
      if ($urandom_range(9) != 0) req.target = 8'($urandom_range(SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < 35) begin
        req.func = FUNC_QUEUE_METER;
      end else if (pick < 65) begin
        req.func = FUNC_QUEUE_DISPLAY;
        case ($urandom_range(9))
          0:       req.payload_ref = '0;
          1:       req.payload_len = '0;
          2, 3:    req.payload_len = 16'($urandom_range(64, 1));
          4, 5:    req.payload_len = 16'($urandom_range(ICON_BYTES + 2, ICON_BYTES - 2));
          default: ;
        endcase
      end else if (pick < 75) begin
        req.func = FUNC_FLOW_UPDATE;
        if ($urandom_range(3) != 0) begin
          req.dev_display_credits = 8'($urandom_range(9));
          req.dev_control_credits = 8'($urandom_range(9));
        end
      end else if (pick < 92) begin
        req.func = FUNC_FLUSH;
      end else if (pick < 96) begin
        req.func = FUNC_RESET_FLOW;
      end else begin
        req.func = FUNC_RESET_FLOW + 3'($urandom_range(3, 1));
      end
      send_item(req);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    in_idle_pct  = 7;
    out_idle_pct = 62;
    send_item(make_item(FUNC_FLUSH, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_METER, 8'd0, 16'hffff, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_METER, 8'(SLOTS - 1), 16'h0, 32'h0, 16'h0, 8'd0, 8'd0,
                        8'd0));
    send_item(make_item(FUNC_QUEUE_METER, 8'(SLOTS), 16'h1234, 32'h0, 16'h0, 8'd0, 8'd0,
                        8'd0));
    send_item(make_item(FUNC_QUEUE_METER, 8'hff, 16'h5678, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'd0, 16'h0, 32'hffffffff, 16'hffff, 8'd0, 8'd0,
                        8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'(SLOTS - 1), 16'h0, 32'h1, 16'h1, 8'd0, 8'd0,
                        8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'd2, 16'h0, 32'h0, 16'h100, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'd2, 16'h0, 32'habcd, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'(SLOTS), 16'h0, 32'habcd, 16'h10, 8'd0, 8'd0,
                        8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'd3, 16'h0, 32'h55aa55aa, 16'(ICON_BYTES), 8'd0,
                        8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_DISPLAY, 8'd4, 16'h0, 32'haa55aa55, 16'(ICON_BYTES + 1),
                        8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_METER, 8'd0, 16'ha5a5, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_FLOW_UPDATE, 8'd0, 16'h0, 32'h0, 16'h0, 8'hff, 8'd1, 8'hff));
    send_item(make_item(FUNC_FLUSH, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_FLUSH, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_FLOW_UPDATE, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'hff, 8'd0));
    send_item(make_item(FUNC_FLUSH, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_RESET_FLOW + 3'd1, 8'd1, 16'hffff, 32'hffffffff, 16'hffff,
                        8'hff, 8'hff, 8'hff));
    send_item(make_item(FUNC_RESET_FLOW + 3'd3, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_RESET_FLOW, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_QUEUE_METER, 8'd1, 16'h0f0f, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_FLUSH, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(FUNC_FLOW_UPDATE, 8'd0, 16'h0, 32'h0, 16'h0, 8'd3, 8'd5, 8'd5));
    send_item(make_item(FUNC_FLUSH, 8'd0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 8'd0));
    wait_drained();

    run_random(109);
    wait_drained();

    in_idle_pct  = 62;
    out_idle_pct = 7;
    run_random(108);
    wait_drained();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(108);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
